### rtl/fba_pkg.sv
// Frame bitmap allocator package: action codes, transaction structs, constants.
// No dependencies; imported by the allocator top level and its checker.
package fba_pkg;

    localparam int          WORD_BITS   = 8 * 4;
    localparam int          FRAME_SHIFT = 12;
    localparam int          FIELD_WORDS = 128;
    localparam logic [31:0] FULL_WORD   = 32'hFFFF_FFFF;
    localparam logic [12:0] FC_RESET    = 13'd4096;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_MARK  = 2'd2,
        ACT_TEST  = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [23:0] frame_address;
        logic [11:0] page_frame;
        logic        kernel_page;
        logic        writable;
    } t_in_item;

    typedef struct packed {
        logic [11:0] result_frame;
        logic        page_changed;
        logic        present;
        logic        rw;
        logic        user;
        logic        in_use;
        logic        no_free;
    } t_out_item;

endpackage

### rtl/frame_bitmap_allocator_unit.sv
// Frame bitmap allocator top level: used/free bitmap in a registered-read memory,
// first-fit word scan, read-modify-write for free and mark. Depends on fba_pkg.
//
//   channel  dir  handshake                 payload
//   in       in   i_in_valid / o_in_stall   i_in_data   (t_in_item)
//   out      out  o_out_valid / i_out_stall o_out_data  (t_out_item)
//   cfg      in   i_cfg_we                  i_cfg_wdata (frame_count)
//
// Allocate of a frameless page: W = min(frame_count/32, words) words are
// scanned one per cycle through the bitmap memory read port.
// Free, mark and test: read, modify/write, result. Other cases: result only.
// One transaction at a time; input is taken while a result waits on stall.
// Reset clears the per-word valid bits at once; no clearing pass.
module frame_bitmap_allocator_unit #(
    parameter int NUM_FRAMES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fba_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fba_pkg::t_out_item o_out_data,
    input  logic              i_cfg_we,
    input  logic [12:0]       i_cfg_wdata
);
    import fba_pkg::*;

    localparam int MAP_WORDS = NUM_FRAMES / WORD_BITS;
    localparam int DEPTH     = (MAP_WORDS < FIELD_WORDS) ? MAP_WORDS : FIELD_WORDS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [7:0] DEPTH_W = 8'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MOD,
        S_SCAN,
        S_DONE
    } t_state;

    t_state      r_state;
    t_in_item    r_in;
    t_out_item   r_res;
    t_out_item   r_out_data;
    logic        r_out_valid;
    logic [12:0] r_frame_count;
    logic [7:0]  r_idx;
    logic [6:0]  r_eidx;
    logic        r_pend;

    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [31:0]      r_rdata;
    logic             r_rvld;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic [7:0]  fc_words;
    logic [7:0]  scan_words;
    logic [31:0] word_eff;
    logic [11:0] tgt_frame;
    logic [6:0]  tgt_word;
    logic        tgt_in_range;
    logic [31:0] tgt_mask;
    logic [31:0] alloc_sum;
    logic [31:0] alloc_onehot;
    logic [4:0]  alloc_bit;
    logic        found;

    function automatic logic [4:0] encode32(input logic [31:0] oh);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (oh[i]) begin
                idx = idx | 5'(i);
            end
        end
        return idx;
    endfunction

    assign fc_words     = r_frame_count[12:5];
    assign scan_words   = (fc_words > DEPTH_W) ? DEPTH_W : fc_words;
    assign word_eff     = r_rvld ? r_rdata : '0;
    assign tgt_frame    = (r_in.action == ACT_FREE) ? r_in.page_frame
                                                    : r_in.frame_address[23:FRAME_SHIFT];
    assign tgt_word     = tgt_frame[11:5];
    assign tgt_in_range = {1'b0, tgt_word} < DEPTH_W;
    assign tgt_mask     = 32'd1 << tgt_frame[4:0];
    assign alloc_sum    = word_eff + 32'd1;
    assign alloc_onehot = ~word_eff & alloc_sum;
    assign alloc_bit    = encode32(alloc_onehot);
    assign found        = r_pend && (word_eff != FULL_WORD);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = tgt_word[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = tgt_word[AW-1:0];
        wr_data = word_eff | tgt_mask;
        case (r_state)
            S_RD: begin
                rd_en = tgt_in_range;
            end
            S_MOD: begin
                wr_en = tgt_in_range &&
                        (r_in.action == ACT_FREE || r_in.action == ACT_MARK);
                if (r_in.action == ACT_FREE) begin
                    wr_data = word_eff & ~tgt_mask;
                end
            end
            S_SCAN: begin
                rd_en   = (r_idx != scan_words) && !found;
                rd_addr = r_idx[AW-1:0];
                wr_en   = found;
                wr_addr = r_eidx[AW-1:0];
                wr_data = word_eff | alloc_sum;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rvld <= r_vld[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_frame_count <= FC_RESET;
            r_pend        <= 1'b0;
            r_idx         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in  <= i_in_data;
                        r_res <= '{result_frame: i_in_data.page_frame, default: 1'b0};
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                        case (i_in_data.action)
                            ACT_ALLOC: begin
                                r_state <= (i_in_data.page_frame != '0) ? S_DONE : S_SCAN;
                            end
                            ACT_FREE: begin
                                r_state <= (i_in_data.page_frame != '0) ? S_RD : S_DONE;
                            end
                            default: begin
                                r_state <= S_RD;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_in.action == ACT_FREE) begin
                        r_res.result_frame <= '0;
                        r_res.page_changed <= 1'b1;
                    end
                    if (r_in.action == ACT_TEST) begin
                        r_res.in_use <= tgt_in_range & word_eff[tgt_frame[4:0]];
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    r_pend <= rd_en;
                    if (rd_en) begin
                        r_idx  <= r_idx + 8'd1;
                        r_eidx <= r_idx[6:0];
                    end
                    if (found) begin
                        r_res.result_frame <= {r_eidx, alloc_bit};
                        r_res.page_changed <= 1'b1;
                        r_res.present      <= 1'b1;
                        r_res.rw           <= r_in.writable;
                        r_res.user         <= ~r_in.kernel_page;
                        r_state            <= S_DONE;
                    end else if (r_idx == scan_words && !r_pend) begin
                        r_res.no_free <= 1'b1;
                        r_state       <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_data  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/fba_checker.sv
// Port-level checker for the frame bitmap allocator, bound to the top level.
// Depends on fba_pkg and frame_bitmap_allocator_unit.
module fba_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input fba_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input fba_pkg::t_out_item o_out_data,
    input logic               i_cfg_we,
    input logic [12:0]        i_cfg_wdata
);
    import fba_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a transaction is in progress");

    a_alloc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.present |->
            o_out_data.page_changed && !o_out_data.no_free && !o_out_data.in_use)
        else $error("inconsistent allocation result");

    a_no_free_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.no_free |->
            !o_out_data.page_changed && !o_out_data.present &&
            !o_out_data.rw && !o_out_data.user)
        else $error("exhaustion result reports a page update");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind frame_bitmap_allocator_unit fba_checker u_fba_checker (.*);
